FILE: design/cip_pkg.sv
`timescale 1ns / 1ps
package cip_pkg;

  // table geometry
  localparam int MODEL_COUNT = 16;
  localparam int MAX_BATCH   = 32;

  // word field widths
  localparam int MODEL_W = 4;
  localparam int BATCH_W = 6;
  localparam int PART_W  = 7;
  localparam int LEVEL_W = 3;
  localparam int UTIL_W  = 17;
  localparam int COEF_W  = 32;
  localparam int FRAC_W  = 16;

  // highest power-of-two level not above MAX_BATCH
  localparam int TOP_LEVEL   = $clog2(MAX_BATCH + 1) - 1;
  localparam int TOP_BATCH   = 1 << TOP_LEVEL;
  localparam int LEVEL_SLOTS = TOP_LEVEL + 1;
  localparam int TAB_DEPTH   = MODEL_COUNT * LEVEL_SLOTS;
  localparam int TAB_AW      = $clog2(TAB_DEPTH);
  localparam int TAB_W       = 2 * UTIL_W;

  // interpolation widths
  localparam int K_W  = $clog2(TOP_LEVEL + 1);
  localparam int WT_W = TOP_LEVEL + 1;
  localparam int IP_W = UTIL_W + WT_W;

  // percent scaling: x = u * part + 50, then x / 100 by reciprocal multiply
  localparam int PCT      = 100;
  localparam int X_W      = UTIL_W + PART_W;
  localparam int RECIP_SH = X_W + $clog2(PCT);
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SH) + 64'(PCT - 1)) / 64'(PCT);
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int S_W      = $clog2(((1 << X_W) - 1) / PCT + 1);

  // weighted sum widths
  localparam int P_W   = COEF_W + S_W + 1;
  localparam int SUM_W = P_W + 2;
  localparam int Q_W   = SUM_W - FRAC_W;

  localparam logic [COEF_W-1:0] ALPHA_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam logic [COEF_W-1:0] ALPHA_MIN = {1'b1, {(COEF_W - 1){1'b0}}};

  // register stages from acceptance to the output register
  localparam int STAGES = 7;

  localparam int CFG_IDX_W = 3;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } cip_action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_L2     = 3'd0,
    CFG_OTHER_L2   = 3'd1,
    CFG_OWN_DRAM   = 3'd2,
    CFG_OTHER_DRAM = 3'd3,
    CFG_BIAS       = 3'd4
  } cip_cfg_idx_t;

  // per-stage load enables, index 1 is the first register stage
  typedef logic [STAGES:1] cip_ld_t;

  typedef struct packed {
    logic [MODEL_W-1:0] model;
    logic [BATCH_W-1:0] batch;
    logic [PART_W-1:0]  part;
  } cip_job_t;

  typedef struct packed {
    logic              en;
    logic [TAB_AW-1:0] addr;
    logic [TAB_W-1:0]  data;
  } cip_wr_t;

  typedef struct packed {
    logic [COEF_W-1:0] own_l2;
    logic [COEF_W-1:0] other_l2;
    logic [COEF_W-1:0] own_dram;
    logic [COEF_W-1:0] other_dram;
    logic [COEF_W-1:0] bias;
  } cip_coef_t;

  typedef struct packed {
    logic [S_W-1:0] l2;
    logic [S_W-1:0] dram;
  } cip_util_t;

endpackage

FILE: design/cip_if.sv
`timescale 1ns / 1ps
interface cip_in_if;
  import cip_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [MODEL_W-1:0] own_model;
  logic [BATCH_W-1:0] own_batch;
  logic [PART_W-1:0]  own_partition;
  logic [MODEL_W-1:0] other_model;
  logic [BATCH_W-1:0] other_batch;
  logic [PART_W-1:0]  other_partition;
  logic [MODEL_W-1:0] entry_model;
  logic [LEVEL_W-1:0] entry_level;
  logic [UTIL_W-1:0]  entry_l2_util;
  logic [UTIL_W-1:0]  entry_dram_util;

  modport source (
    output valid, action, own_model, own_batch, own_partition,
           other_model, other_batch, other_partition,
           entry_model, entry_level, entry_l2_util, entry_dram_util,
    input  ready
  );

  modport sink (
    input  valid, action, own_model, own_batch, own_partition,
           other_model, other_batch, other_partition,
           entry_model, entry_level, entry_l2_util, entry_dram_util,
    output ready
  );
endinterface

interface cip_out_if;
  import cip_pkg::*;

  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] alpha;
  logic              alpha_saturated;

  modport source (
    output valid, alpha, alpha_saturated,
    input  ready
  );

  modport sink (
    input  valid, alpha, alpha_saturated,
    output ready
  );
endinterface

FILE: design/cip_ram.sv
`timescale 1ns / 1ps
module cip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/cip_job_path.sv
`timescale 1ns / 1ps
module cip_job_path (
  input  logic               clk,
  input  cip_pkg::cip_ld_t   ld,
  input  cip_pkg::cip_wr_t   wr,
  input  cip_pkg::cip_job_t  job,
  output cip_pkg::cip_util_t util
);
  import cip_pkg::*;

  localparam int MP_W = X_W + RECIP_W;

  function automatic logic [UTIL_W-1:0] interp(
    input logic [UTIL_W-1:0] lo,
    input logic [UTIL_W-1:0] hi,
    input logic [WT_W-1:0]   wlo,
    input logic [WT_W-1:0]   whi,
    input logic [WT_W-1:0]   below,
    input logic [K_W-1:0]    k
  );
    logic [IP_W-1:0] acc;
    acc = IP_W'(lo) * IP_W'(wlo) + IP_W'(hi) * IP_W'(whi) + IP_W'(below >> 1);
    return UTIL_W'(acc >> k);
  endfunction

  // stage 0: bracket the batch and form both table addresses
  logic [BATCH_W-1:0] b_c;
  logic [K_W-1:0]     k0;
  logic [WT_W-1:0]    below0;
  logic [WT_W-1:0]    d0;
  logic               top0;
  logic               ok0;
  logic [TAB_AW-1:0]  base0;
  logic [TAB_AW-1:0]  addr_lo0;
  logic [TAB_AW-1:0]  addr_hi0;

  always_comb begin
    b_c = job.batch;
    if (b_c == '0) begin
      b_c = BATCH_W'(1);
    end
    if (int'(b_c) > TOP_BATCH) begin
      b_c = BATCH_W'(TOP_BATCH);
    end
    k0 = '0;
    for (int i = 0; i <= TOP_LEVEL; i++) begin
      if (b_c[i]) begin
        k0 = K_W'(i);
      end
    end
    below0   = WT_W'(1) << k0;
    d0       = WT_W'(b_c) - below0;
    top0     = (int'(k0) == TOP_LEVEL);
    ok0      = (int'(job.model) < MODEL_COUNT);
    base0    = TAB_AW'(job.model) * TAB_AW'(LEVEL_SLOTS);
    addr_lo0 = base0 + TAB_AW'(k0);
    addr_hi0 = top0 ? addr_lo0 : addr_lo0 + TAB_AW'(1);
  end

  // stage 1: table copies for the lower and upper bracket level
  logic [TAB_W-1:0] lo1;
  logic [TAB_W-1:0] hi1;

  cip_ram #(.WIDTH(TAB_W), .DEPTH(TAB_DEPTH)) u_ram_lo (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (ld[1]),
    .raddr (addr_lo0),
    .rdata (lo1)
  );

  cip_ram #(.WIDTH(TAB_W), .DEPTH(TAB_DEPTH)) u_ram_hi (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (ld[1]),
    .raddr (addr_hi0),
    .rdata (hi1)
  );

  logic [K_W-1:0]    k1_r;
  logic [WT_W-1:0]   d1_r;
  logic              top1_r;
  logic              ok1_r;
  logic [PART_W-1:0] part1_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      k1_r    <= k0;
      d1_r    <= d0;
      top1_r  <= top0;
      ok1_r   <= ok0;
      part1_r <= job.part;
    end
  end

  // interpolate between the two levels
  logic [UTIL_W-1:0] lo_l2, lo_dr, hi_l2, hi_dr;
  logic [WT_W-1:0]   below1;
  logic [WT_W-1:0]   wlo1;
  logic [UTIL_W-1:0] u_l2_nxt, u_dr_nxt;

  always_comb begin
    lo_l2    = ok1_r ? lo1[TAB_W-1:UTIL_W] : '0;
    lo_dr    = ok1_r ? lo1[UTIL_W-1:0]     : '0;
    hi_l2    = ok1_r ? hi1[TAB_W-1:UTIL_W] : '0;
    hi_dr    = ok1_r ? hi1[UTIL_W-1:0]     : '0;
    below1   = WT_W'(1) << k1_r;
    wlo1     = below1 - d1_r;
    u_l2_nxt = top1_r ? hi_l2 : interp(lo_l2, hi_l2, wlo1, d1_r, below1, k1_r);
    u_dr_nxt = top1_r ? hi_dr : interp(lo_dr, hi_dr, wlo1, d1_r, below1, k1_r);
  end

  // stage 2: times partition, plus half of the percent divisor
  logic [UTIL_W-1:0] u2_l2_r, u2_dr_r;
  logic [PART_W-1:0] part2_r;
  logic [X_W-1:0]    x_l2_nxt, x_dr_nxt;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      u2_l2_r <= u_l2_nxt;
      u2_dr_r <= u_dr_nxt;
      part2_r <= part1_r;
    end
  end

  always_comb begin
    x_l2_nxt = X_W'(u2_l2_r) * X_W'(part2_r) + X_W'(PCT / 2);
    x_dr_nxt = X_W'(u2_dr_r) * X_W'(part2_r) + X_W'(PCT / 2);
  end

  // stage 3: divide by 100 through the reciprocal, exact for x below 2^X_W
  logic [X_W-1:0]  x3_l2_r, x3_dr_r;
  logic [MP_W-1:0] mp_l2, mp_dr;
  logic [S_W-1:0]  s_l2_nxt, s_dr_nxt;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      x3_l2_r <= x_l2_nxt;
      x3_dr_r <= x_dr_nxt;
    end
  end

  always_comb begin
    mp_l2    = MP_W'(x3_l2_r) * MP_W'(RECIP);
    mp_dr    = MP_W'(x3_dr_r) * MP_W'(RECIP);
    s_l2_nxt = S_W'(mp_l2 >> RECIP_SH);
    s_dr_nxt = S_W'(mp_dr >> RECIP_SH);
  end

  // stage 4: scaled utilizations
  logic [S_W-1:0] s4_l2_r, s4_dr_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_l2_r <= s_l2_nxt;
      s4_dr_r <= s_dr_nxt;
    end
  end

  assign util.l2   = s4_l2_r;
  assign util.dram = s4_dr_r;

endmodule

FILE: design/cip_combine.sv
`timescale 1ns / 1ps
module cip_combine (
  input  logic                      clk,
  input  cip_pkg::cip_ld_t          ld,
  input  cip_pkg::cip_coef_t        coef,
  input  cip_pkg::cip_util_t        own,
  input  cip_pkg::cip_util_t        other,
  output logic [cip_pkg::COEF_W-1:0] alpha,
  output logic                      alpha_sat
);
  import cip_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (FRAC_W - 1);

  // stage 5: four coefficient products
  logic signed [COEF_W-1:0] c_ol2, c_xl2, c_odr, c_xdr;
  logic signed [S_W:0]      s_ol2, s_xl2, s_odr, s_xdr;
  logic signed [P_W-1:0]    p0_nxt, p1_nxt, p2_nxt, p3_nxt;

  always_comb begin
    c_ol2  = $signed(coef.own_l2);
    c_xl2  = $signed(coef.other_l2);
    c_odr  = $signed(coef.own_dram);
    c_xdr  = $signed(coef.other_dram);
    s_ol2  = $signed({1'b0, own.l2});
    s_xl2  = $signed({1'b0, other.l2});
    s_odr  = $signed({1'b0, own.dram});
    s_xdr  = $signed({1'b0, other.dram});
    p0_nxt = c_ol2 * s_ol2;
    p1_nxt = c_xl2 * s_xl2;
    p2_nxt = c_odr * s_odr;
    p3_nxt = c_xdr * s_xdr;
  end

  logic signed [P_W-1:0] p0_r, p1_r, p2_r, p3_r;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
    end
  end

  // stage 6: two partial sums, bias and rounding folded into the second
  logic signed [SUM_W-1:0] bias_ext;
  logic signed [SUM_W-1:0] sa_nxt, sb_nxt;

  always_comb begin
    bias_ext = SUM_W'($signed(coef.bias)) <<< FRAC_W;
    sa_nxt   = SUM_W'(p0_r) + SUM_W'(p1_r);
    sb_nxt   = SUM_W'(p2_r) + SUM_W'(p3_r) + bias_ext + HALF_LSB;
  end

  logic signed [SUM_W-1:0] sa_r, sb_r;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
    end
  end

  // stage 7: final add, drop fraction, clip to 32 bits
  logic signed [SUM_W-1:0]  tot;
  logic signed [Q_W-1:0]    q;
  logic [Q_W-COEF_W:0]      q_hi;
  logic                     sat_nxt;
  logic [COEF_W-1:0]        alpha_nxt;

  always_comb begin
    tot     = sa_r + sb_r;
    q       = Q_W'(tot >>> FRAC_W);
    q_hi    = q[Q_W-1:COEF_W-1];
    sat_nxt = !((&q_hi) || !(|q_hi));
    if (!sat_nxt) begin
      alpha_nxt = q[COEF_W-1:0];
    end else if (q[Q_W-1]) begin
      alpha_nxt = ALPHA_MIN;
    end else begin
      alpha_nxt = ALPHA_MAX;
    end
  end

  logic [COEF_W-1:0] alpha_r;
  logic              sat_r;

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      alpha_r <= alpha_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign alpha     = alpha_r;
  assign alpha_sat = sat_r;

endmodule

FILE: design/corun_interference_predictor.sv
`timescale 1ns / 1ps
// Co-run interference predictor. A load word (action 0) writes one L2/DRAM
// utilization pair of the model x level table at the edge it is accepted and
// gives no result; a query word (action 1) gives one result: alpha in signed
// Q31.0, clipped to 32 bits with alpha_saturated set when clipped. The block
// takes one word per clock and keeps taking words while a finished result
// waits at the output, until all seven stages hold queries; a query's result
// shows on out_word once it reaches the output register. The depth is set
// by the work per job: table read, bracket interpolation multiply, partition
// multiply, divide-by-100 reciprocal multiply, coefficient multiply, then two
// add stages and the clip into the output register. Results come out in query
// order, and a query sees every load accepted before it. The 96-entry table is
// held in four identical copies (low and high bracket level for each of the
// two jobs) so that all four reads of a query are done in its acceptance
// cycle; all copies take each kept load. Table entries hold garbage until
// loaded, so a query must only touch loaded entries. Coefficients are written
// over the cfg port and must only be changed while the block is idle.
module corun_interference_predictor (
  input  logic                          clk,
  input  logic                          rst_n,
  cip_in_if.sink                        in_word,
  cip_out_if.source                     out_word,
  input  logic                          cfg_we,
  input  logic [cip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cip_pkg::COEF_W-1:0]    cfg_wdata
);
  import cip_pkg::*;

  // coefficient registers
  cip_coef_t coef_r, coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_L2:     coef_nxt.own_l2     = cfg_wdata;
        CFG_OTHER_L2:   coef_nxt.other_l2   = cfg_wdata;
        CFG_OWN_DRAM:   coef_nxt.own_dram   = cfg_wdata;
        CFG_OTHER_DRAM: coef_nxt.other_dram = cfg_wdata;
        CFG_BIAS:       coef_nxt.bias       = cfg_wdata;
        default:        coef_nxt            = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // pipeline control: a stage loads when it is empty or its successor loads
  logic [STAGES:1] vld_r, vld_nxt;
  cip_ld_t         ld;
  logic            in_acc;
  logic            query_acc;

  always_comb begin
    ld[STAGES] = !vld_r[STAGES] || out_word.ready;
    for (int i = STAGES - 1; i >= 1; i--) begin
      ld[i] = !vld_r[i] || ld[i+1];
    end
  end

  assign in_word.ready = ld[1];
  assign in_acc        = in_word.valid && ld[1];
  assign query_acc     = in_acc && (in_word.action == ACT_QUERY);

  always_comb begin
    vld_nxt = vld_r;
    if (ld[1]) begin
      vld_nxt[1] = query_acc;
    end
    for (int i = 2; i <= STAGES; i++) begin
      if (ld[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // table write from a load word; bad slots are dropped
  cip_wr_t wr;

  always_comb begin
    wr.en   = in_acc && (in_word.action == ACT_LOAD)
              && (int'(in_word.entry_model) < MODEL_COUNT)
              && (int'(in_word.entry_level) <= TOP_LEVEL);
    wr.addr = TAB_AW'(in_word.entry_model) * TAB_AW'(LEVEL_SLOTS)
              + TAB_AW'(in_word.entry_level);
    wr.data = {in_word.entry_l2_util, in_word.entry_dram_util};
  end

  // per-job lookup, interpolation and partition scaling
  cip_job_t  own_job, other_job;
  cip_util_t own_util, other_util;

  assign own_job.model   = in_word.own_model;
  assign own_job.batch   = in_word.own_batch;
  assign own_job.part    = in_word.own_partition;
  assign other_job.model = in_word.other_model;
  assign other_job.batch = in_word.other_batch;
  assign other_job.part  = in_word.other_partition;

  cip_job_path u_own (
    .clk  (clk),
    .ld   (ld),
    .wr   (wr),
    .job  (own_job),
    .util (own_util)
  );

  cip_job_path u_other (
    .clk  (clk),
    .ld   (ld),
    .wr   (wr),
    .job  (other_job),
    .util (other_util)
  );

  // weighted sum, rounding and clip
  logic [COEF_W-1:0] alpha;
  logic              alpha_sat;

  cip_combine u_combine (
    .clk       (clk),
    .ld        (ld),
    .coef      (coef_r),
    .own       (own_util),
    .other     (other_util),
    .alpha     (alpha),
    .alpha_sat (alpha_sat)
  );

  assign out_word.valid           = vld_r[STAGES];
  assign out_word.alpha           = alpha;
  assign out_word.alpha_saturated = alpha_sat;

`ifndef SYNTH
  // a load word never enters the result pipeline
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_word.action == ACT_LOAD)) |=> !vld_r[1])
    else $error("load word entered result pipeline");

  // every accepted query occupies the first stage next cycle
  a_query_enters: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> vld_r[1])
    else $error("accepted query lost at first stage");

  // the last inner stage holds its word while the output register is stuck
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[STAGES-1] && !ld[STAGES]) |=> vld_r[STAGES-1])
    else $error("word dropped under output stall");

  // a clipped result is one of the two range limits
  a_sat_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.alpha_saturated) |->
      ((out_word.alpha == ALPHA_MAX) || (out_word.alpha == ALPHA_MIN)))
    else $error("saturated alpha not at a range limit");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
package cip_tb_pkg;
  import cip_pkg::*;

  typedef struct {
    cip_action_t        action;
    logic [MODEL_W-1:0] own_model;
    logic [BATCH_W-1:0] own_batch;
    logic [PART_W-1:0]  own_partition;
    logic [MODEL_W-1:0] other_model;
    logic [BATCH_W-1:0] other_batch;
    logic [PART_W-1:0]  other_partition;
    logic [MODEL_W-1:0] entry_model;
    logic [LEVEL_W-1:0] entry_level;
    logic [UTIL_W-1:0]  entry_l2_util;
    logic [UTIL_W-1:0]  entry_dram_util;
  } cip_word_t;

  typedef struct {
    logic [COEF_W-1:0] alpha;
    logic              sat;
  } alpha_result_t;

  // lower bracket level of a batch, after clamping to 1..TOP_BATCH
  function automatic int low_level(input logic [BATCH_W-1:0] batch);
    int b;
    int k;
    b = (batch == 0) ? 1 : ((batch > TOP_BATCH) ? TOP_BATCH : int'(batch));
    k = 0;
    while (k < TOP_LEVEL && (2 << k) <= b) k++;
    return k;
  endfunction

  class alpha_scoreboard;
    longint        coef [5];
    logic [UTIL_W-1:0] l2_tab [MODEL_COUNT][LEVEL_SLOTS];
    logic [UTIL_W-1:0] dram_tab [MODEL_COUNT][LEVEL_SLOTS];
    alpha_result_t pending_alpha [$];
    int            mismatches;
    int            loads;
    int            bad_loads;
    int            queries;
    int            clipped;

    function void set_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      if (idx <= CFG_BIAS) coef[idx] = longint'($signed(val));
    endfunction

    function int outstanding();
      return pending_alpha.size();
    endfunction

    // interpolated utilizations of one job, scaled by its partition percent
    function void scaled_utils(input logic [MODEL_W-1:0] model,
                               input logic [BATCH_W-1:0] batch,
                               input logic [PART_W-1:0] part,
                               output longint l2_s, output longint dram_s);
      int     k;
      int     kt;
      longint b;
      longint below;
      longint d;
      longint ul;
      longint ud;
      k = low_level(batch);
      kt = (k < TOP_LEVEL) ? k + 1 : k;
      b = (batch == 0) ? 1 : ((batch > TOP_BATCH) ? TOP_BATCH : longint'(batch));
      below = longint'(1) << k;
      d = b - below;
      if (kt == k) begin
        ul = longint'(l2_tab[model][kt]);
        ud = longint'(dram_tab[model][kt]);
      end else begin
        ul = (longint'(l2_tab[model][k]) * (below - d) + longint'(l2_tab[model][kt]) * d
              + (below >> 1)) >> k;
        ud = (longint'(dram_tab[model][k]) * (below - d) + longint'(dram_tab[model][kt]) * d
              + (below >> 1)) >> k;
      end
      l2_s = (ul * longint'(part) + 50) / 100;
      dram_s = (ud * longint'(part) + 50) / 100;
    endfunction

    function void note_word(input cip_word_t w);
      longint        own_l2;
      longint        own_dram;
      longint        oth_l2;
      longint        oth_dram;
      longint        sum;
      longint        q;
      alpha_result_t r;
      if (w.action == ACT_LOAD) begin
        loads++;
        if (w.entry_level <= TOP_LEVEL) begin
          l2_tab[w.entry_model][w.entry_level] = w.entry_l2_util;
          dram_tab[w.entry_model][w.entry_level] = w.entry_dram_util;
        end else begin
          bad_loads++;
        end
        return;
      end
      queries++;
      scaled_utils(w.own_model, w.own_batch, w.own_partition, own_l2, own_dram);
      scaled_utils(w.other_model, w.other_batch, w.other_partition, oth_l2, oth_dram);
      sum = coef[CFG_OWN_L2] * own_l2 + coef[CFG_OTHER_L2] * oth_l2
          + coef[CFG_OWN_DRAM] * own_dram + coef[CFG_OTHER_DRAM] * oth_dram
          + coef[CFG_BIAS] * 65536;
      q = (sum + 32768) >>> FRAC_W;
      r.sat = 1'b0;
      if (q > longint'(ALPHA_MAX)) begin
        q = longint'(ALPHA_MAX);
        r.sat = 1'b1;
      end
      if (q < longint'($signed(ALPHA_MIN))) begin
        q = longint'($signed(ALPHA_MIN));
        r.sat = 1'b1;
      end
      if (r.sat) clipped++;
      r.alpha = q[COEF_W-1:0];
      pending_alpha = {pending_alpha, r};
    endfunction

    function void check_result(input logic [COEF_W-1:0] alpha, input logic sat);
      alpha_result_t want;
      if (pending_alpha.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending, alpha %h sat %b", $time, alpha, sat);
        return;
      end
      want = pending_alpha.pop_front();
      if (alpha !== want.alpha) begin
        mismatches++;
        $display("%0t: alpha expected %h actual %h", $time, want.alpha, alpha);
      end
      if (sat !== want.sat) begin
        mismatches++;
        $display("%0t: alpha_saturated expected %b actual %b", $time, want.sat, sat);
      end
    endfunction
  endclass
endpackage

module testbench;
  import cip_pkg::*;
  import cip_tb_pkg::*;

  // coefficient sets, one phase each, then random words under each
  localparam int PHASES         = 7;
  localparam int WORDS_PER_PHASE = 95;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_wdata;

  cip_in_if  in_word ();
  cip_out_if out_word ();

  corun_interference_predictor i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  alpha_scoreboard alpha_sb = new;

  // table slots that stimulus has loaded, so queries never read garbage
  bit loaded [MODEL_COUNT][LEVEL_SLOTS];
  // calm stretches: no idling on that side until it flips back
  bit in_calm;
  bit out_calm;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // accepted input words feed the predictor
  always @(posedge clk) begin
    cip_word_t w;
    if (rst_n && in_word.valid && in_word.ready) begin
      w.action          = cip_action_t'(in_word.action);
      w.own_model       = in_word.own_model;
      w.own_batch       = in_word.own_batch;
      w.own_partition   = in_word.own_partition;
      w.other_model     = in_word.other_model;
      w.other_batch     = in_word.other_batch;
      w.other_partition = in_word.other_partition;
      w.entry_model     = in_word.entry_model;
      w.entry_level     = in_word.entry_level;
      w.entry_l2_util   = in_word.entry_l2_util;
      w.entry_dram_util = in_word.entry_dram_util;
      alpha_sb.note_word(w);
    end
  end

  // accepted results are checked in order
  always @(posedge clk) begin
    if (rst_n && out_word.valid && out_word.ready)
      alpha_sb.check_result(out_word.alpha, out_word.alpha_saturated);
  end

  // idle draw per word, with occasional flips into or out of a calm stretch
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 13));
  endfunction

  // result side may hold ready low for a random gap before each result
  initial begin
    int gap;
    out_word.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_word.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_word.ready <= 1'b1;
      @(posedge clk);
      while (!(out_word.valid && out_word.ready)) @(posedge clk);
    end
  end

  function automatic logic [UTIL_W-1:0] pick_util();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return UTIL_W'(65536);
      2: return '1;
      3: return UTIL_W'($urandom);
      default: return UTIL_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // mostly 1..32, with zero, oversize and exact powers mixed in
  function automatic logic [BATCH_W-1:0] pick_batch();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return BATCH_W'($urandom_range(TOP_BATCH + 1, (1 << BATCH_W) - 1));
      2: return BATCH_W'(1 << $urandom_range(0, TOP_LEVEL));
      default: return BATCH_W'($urandom_range(1, TOP_BATCH));
    endcase
  endfunction

  function automatic logic [PART_W-1:0] pick_part();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PART_W'(100);
      2: return PART_W'($urandom_range(101, (1 << PART_W) - 1));
      default: return PART_W'($urandom_range(0, 100));
    endcase
  endfunction

  // unused fields of a word carry random noise
  function automatic cip_word_t noise_word();
    cip_word_t w;
    w.action          = ACT_LOAD;
    w.own_model       = MODEL_W'($urandom);
    w.own_batch       = BATCH_W'($urandom);
    w.own_partition   = PART_W'($urandom);
    w.other_model     = MODEL_W'($urandom);
    w.other_batch     = BATCH_W'($urandom);
    w.other_partition = PART_W'($urandom);
    w.entry_model     = MODEL_W'($urandom);
    w.entry_level     = LEVEL_W'($urandom);
    w.entry_l2_util   = UTIL_W'($urandom);
    w.entry_dram_util = UTIL_W'($urandom);
    return w;
  endfunction

  function automatic cip_word_t load_word(input int m, input int lvl,
                                          input logic [UTIL_W-1:0] l2,
                                          input logic [UTIL_W-1:0] dram);
    cip_word_t w;
    w = noise_word();
    w.entry_model     = MODEL_W'(m);
    w.entry_level     = LEVEL_W'(lvl);
    w.entry_l2_util   = l2;
    w.entry_dram_util = dram;
    return w;
  endfunction

  function automatic cip_word_t query_word(input int om, input int ob, input int op,
                                           input int xm, input int xb, input int xp);
    cip_word_t w;
    w = noise_word();
    w.action          = ACT_QUERY;
    w.own_model       = MODEL_W'(om);
    w.own_batch       = BATCH_W'(ob);
    w.own_partition   = PART_W'(op);
    w.other_model     = MODEL_W'(xm);
    w.other_batch     = BATCH_W'(xb);
    w.other_partition = PART_W'(xp);
    return w;
  endfunction

  // valid stays high across back-to-back words, dropped only for a gap
  task automatic send_word(input cip_word_t w);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.valid           <= 1'b1;
    in_word.action          <= w.action;
    in_word.own_model       <= w.own_model;
    in_word.own_batch       <= w.own_batch;
    in_word.own_partition   <= w.own_partition;
    in_word.other_model     <= w.other_model;
    in_word.other_batch     <= w.other_batch;
    in_word.other_partition <= w.other_partition;
    in_word.entry_model     <= w.entry_model;
    in_word.entry_level     <= w.entry_level;
    in_word.entry_l2_util   <= w.entry_l2_util;
    in_word.entry_dram_util <= w.entry_dram_util;
    @(posedge clk);
    while (!in_word.ready) @(posedge clk);
    if (w.action == ACT_LOAD && w.entry_level <= TOP_LEVEL)
      loaded[w.entry_model][w.entry_level] = 1'b1;
  endtask

  // load any bracket slot of this job that has never been written
  task automatic cover_bracket(input logic [MODEL_W-1:0] m, input logic [BATCH_W-1:0] b);
    int k;
    int kt;
    k = low_level(b);
    kt = (k < TOP_LEVEL) ? k + 1 : k;
    for (int lvl = k; lvl <= kt; lvl++)
      if (!loaded[m][lvl]) send_word(load_word(m, lvl, pick_util(), pick_util()));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    alpha_sb.set_coef(idx, val);
  endtask

  // one coefficient set per phase, extremes included
  task automatic program_coefs(input int phase);
    logic [COEF_W-1:0] c [5];
    for (int r = 0; r < 5; r++) begin
      case (phase % 6)
        0: c[r] = COEF_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
        1: c[r] = ALPHA_MAX;
        2: c[r] = ALPHA_MIN;
        3: c[r] = (r == CFG_BIAS) ? COEF_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19))
                                  : '0;
        4: c[r] = $urandom;
        default: c[r] = r[0] ? ALPHA_MIN : ALPHA_MAX;
      endcase
    end
    for (int r = 0; r <= CFG_BIAS; r++) write_reg(CFG_IDX_W'(r), c[r]);
    // indexes past the last register must leave the set untouched
    write_reg(CFG_IDX_W'(CFG_BIAS + $urandom_range(1, 3)), $urandom);
    cfg_we <= 1'b0;
  endtask

  // idle the block: no word offered, every result back, pipeline flushed
  task automatic settle();
    in_word.valid <= 1'b0;
    @(posedge clk);
    while (alpha_sb.outstanding() != 0) @(posedge clk);
    repeat (STAGES + 4) @(posedge clk);
  endtask

  initial begin
    cip_word_t w;
    int        sent;
    in_word.valid           <= 1'b0;
    in_word.action          <= ACT_LOAD;
    in_word.own_model       <= '0;
    in_word.own_batch       <= '0;
    in_word.own_partition   <= '0;
    in_word.other_model     <= '0;
    in_word.other_batch     <= '0;
    in_word.other_partition <= '0;
    in_word.entry_model     <= '0;
    in_word.entry_level     <= '0;
    in_word.entry_l2_util   <= '0;
    in_word.entry_dram_util <= '0;
    cfg_we                  <= 1'b0;
    cfg_index               <= CFG_OWN_L2;
    cfg_wdata               <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    program_coefs(0);

    // directed: fill the corner models, model 0 partly with extreme utilizations
    for (int lvl = 0; lvl <= TOP_LEVEL; lvl++) begin
      case (lvl)
        0: send_word(load_word(0, lvl, '0, '1));
        1: send_word(load_word(0, lvl, UTIL_W'(65536), '0));
        2: send_word(load_word(0, lvl, '1, UTIL_W'(65536)));
        default: send_word(load_word(0, lvl, pick_util(), pick_util()));
      endcase
      send_word(load_word(MODEL_COUNT - 1, lvl, pick_util(), pick_util()));
    end
    // loads to levels past the top are dropped
    send_word(load_word(3, TOP_LEVEL + 1, '1, '1));
    send_word(load_word(9, 7, '1, '1));
    // batch zero, oversize batch, partitions at 0, 100 and above 100
    send_word(query_word(0, 0, 100, 15, 63, 127));
    send_word(query_word(0, 1, 0, 15, TOP_BATCH, 100));
    send_word(query_word(0, 31, 101, 15, TOP_BATCH + 1, 50));
    send_word(query_word(15, 3, 100, 0, 17, 1));
    send_word(query_word(0, 2, 127, 0, 24, 99));
    send_word(query_word(15, 5, 100, 15, 16, 100));
    // overwrite of a loaded slot is seen by the next query
    send_word(load_word(0, TOP_LEVEL, '1, '0));
    send_word(query_word(0, TOP_BATCH, 100, 0, 48, 100));

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        program_coefs(p);
      end
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 3) begin
          // plain load, now and then to a dropped level
          w = load_word($urandom_range(0, MODEL_COUNT - 1),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(TOP_LEVEL + 1, 7)
                                                    : $urandom_range(0, TOP_LEVEL),
                        pick_util(), pick_util());
          send_word(w);
          if (w.entry_level <= TOP_LEVEL) sent++;
        end else begin
          w = query_word($urandom_range(0, MODEL_COUNT - 1), pick_batch(), pick_part(),
                         $urandom_range(0, MODEL_COUNT - 1), pick_batch(), pick_part());
          cover_bracket(w.own_model, w.own_batch);
          cover_bracket(w.other_model, w.other_batch);
          send_word(w);
          sent++;
        end
      end
    end
    settle();

    $display("run covered %0d loads (%0d to dropped levels) and %0d queries",
             alpha_sb.loads, alpha_sb.bad_loads, alpha_sb.queries);
    $display("%0d coefficient sets, %0d results clipped", PHASES, alpha_sb.clipped);
    if (alpha_sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
design/cip_pkg.sv
design/cip_if.sv
design/cip_ram.sv
design/cip_job_path.sv
design/cip_combine.sv
design/corun_interference_predictor.sv
dv/testbench.sv
